[rtl/irtx_pkg.sv]
// Shared types and constants for the IR remote frame transmitter.
// Payload structs, phase enum, register indexes and reset values.
// No dependencies.
package irtx_pkg;

   localparam int CLOCKS_PER_US     = 16;
   localparam int NEC_ZERO_SPACE_US = 560;

   localparam int US_W      = 16;
   localparam int SEG_W     = 20;
   localparam int CARRIER_W = 9;
   localparam int DATA_W    = 32;
   localparam int COUNT_W   = 6;

   localparam logic [SEG_W-1:0] SEG_MAX = {SEG_W{1'b1}};

   localparam logic [CARRIER_W-1:0] NEC_TOP  = 9'd420;
   localparam logic [CARRIER_W-1:0] NEC_CMP  = 9'd140;
   localparam logic [CARRIER_W-1:0] SONY_TOP = 9'd399;
   localparam logic [CARRIER_W-1:0] SONY_CMP = 9'd133;
   localparam logic [COUNT_W-1:0]   MAX_BITS = 6'd32;

   localparam logic PROTO_NEC  = 1'b0;
   localparam logic PROTO_SONY = 1'b1;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // Configuration register file
   localparam int CSR_COUNT   = 8;
   localparam int CSR_SEL_W   = 3;
   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_SEL_W-1:0] CSR_NEC_HDR_MARK  = 3'd0;
   localparam logic [CSR_SEL_W-1:0] CSR_NEC_HDR_SPACE = 3'd1;
   localparam logic [CSR_SEL_W-1:0] CSR_NEC_BIT_MARK  = 3'd2;
   localparam logic [CSR_SEL_W-1:0] CSR_NEC_ONE_SPACE = 3'd3;
   localparam logic [CSR_SEL_W-1:0] CSR_SONY_HDR_MARK = 3'd4;
   localparam logic [CSR_SEL_W-1:0] CSR_SONY_SPACE    = 3'd5;
   localparam logic [CSR_SEL_W-1:0] CSR_SONY_ONE_MARK = 3'd6;
   localparam logic [CSR_SEL_W-1:0] CSR_SONY_ZERO_MARK = 3'd7;

   typedef logic [CSR_COUNT-1:0][US_W-1:0] csr_file_type;

   localparam csr_file_type CSR_RESET = {
      16'd600, 16'd1200, 16'd600, 16'd2400,
      16'd1600, 16'd560, 16'd4500, 16'd9000
   };

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_HDR_MARK   = 3'd1,
      PH_HDR_SPACE  = 3'd2,
      PH_BIT_MARK   = 3'd3,
      PH_BIT_SPACE  = 3'd4,
      PH_TRAIL_MARK = 3'd5
   } phase_type;

   typedef struct packed {
      logic              command;
      logic [DATA_W-1:0] frame_data;
      logic [COUNT_W-1:0] bit_count;
      logic              protocol;
   } req_word_type;

   typedef struct packed {
      logic ir_level;
      logic busy_res;
      logic start_rejected;
   } rsp_word_type;

   typedef struct packed {
      logic result_valid;
      logic settling;
   } core_status_type;

endpackage

[rtl/irtx_csr.sv]
// Configuration register file for the IR transmitter.
// Eight 16-bit duration registers; depends on irtx_pkg.
module irtx_csr
   import irtx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [US_W-1:0]        csr_wdata,
   output csr_file_type           csr_file
);

   csr_file_type file_ff;
   csr_file_type file_in;

   assign csr_ready = 1'b1;
   assign csr_file  = file_ff;

   always_comb begin
      file_in = file_ff;
      // drop writes beyond the register list
      if (csr_valid && (csr_index < CSR_INDEX_W'(CSR_COUNT))) begin
         file_in[csr_index[CSR_SEL_W-1:0]] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_ff <= CSR_RESET;
      end else begin
         file_ff <= file_in;
      end
   end

endmodule

[rtl/irtx_core.sv]
// Frame sequencer: phase, shift word, segment timer and carrier counter.
// One tick or start per accepted word; depends on irtx_pkg.
module irtx_core
   import irtx_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_word_type    req_word,
   input  csr_file_type    csr_file,
   output rsp_word_type    result,
   output core_status_type status
);

   localparam int PROD_RAW = US_W + $clog2(CLOCKS_PER_US + 1);
   localparam int PROD_W   = (PROD_RAW > SEG_W) ? PROD_RAW : SEG_W + 1;

   typedef struct packed {
      phase_type          phase;
      logic [DATA_W-1:0]  shift_word;
      logic [COUNT_W-1:0] bits_left;
      logic [SEG_W-1:0]   seg_left;
      logic [CARRIER_W-1:0] carrier;
      logic               proto;
   } tx_state_type;

   tx_state_type st_ff, st_in;
   tx_state_type mid, after;
   logic         settle_ff, settle_in;
   logic         rejected;
   logic         active;
   logic         still;

   function automatic logic is_mark(phase_type ph);
      return (ph == PH_HDR_MARK) || (ph == PH_BIT_MARK) || (ph == PH_TRAIL_MARK);
   endfunction

   function automatic logic [US_W-1:0] seg_us(phase_type ph, logic proto, logic one,
                                             csr_file_type cfg);
      logic [US_W-1:0] us;
      us = '0;
      if (proto == PROTO_NEC) begin
         unique case (ph)
            PH_HDR_MARK:   us = cfg[CSR_NEC_HDR_MARK];
            PH_HDR_SPACE:  us = cfg[CSR_NEC_HDR_SPACE];
            PH_BIT_MARK:   us = cfg[CSR_NEC_BIT_MARK];
            PH_BIT_SPACE:  us = one ? cfg[CSR_NEC_ONE_SPACE] : US_W'(NEC_ZERO_SPACE_US);
            PH_TRAIL_MARK: us = cfg[CSR_NEC_BIT_MARK];
            default:       us = '0;
         endcase
      end else begin
         unique case (ph)
            PH_HDR_MARK:  us = cfg[CSR_SONY_HDR_MARK];
            PH_HDR_SPACE: us = cfg[CSR_SONY_SPACE];
            PH_BIT_MARK:  us = one ? cfg[CSR_SONY_ONE_MARK] : cfg[CSR_SONY_ZERO_MARK];
            PH_BIT_SPACE: us = cfg[CSR_SONY_SPACE];
            default:      us = '0;
         endcase
      end
      return us;
   endfunction

   function automatic logic [SEG_W-1:0] seg_ticks(logic [US_W-1:0] us);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(us) * PROD_W'(CLOCKS_PER_US);
      if (prod > PROD_W'(SEG_MAX)) begin
         return SEG_MAX;
      end
      return prod[SEG_W-1:0];
   endfunction

   function automatic phase_type after_bits(logic [COUNT_W-1:0] bits, logic proto);
      if (bits != '0) begin
         return PH_BIT_MARK;
      end
      return (proto == PROTO_NEC) ? PH_TRAIL_MARK : PH_IDLE;
   endfunction

   // one move to the following segment; zero-length results are walked again
   function automatic tx_state_type advance_step(tx_state_type s, csr_file_type cfg);
      tx_state_type n;
      n = s;
      unique case (s.phase)
         PH_HDR_MARK:  n.phase = PH_HDR_SPACE;
         PH_HDR_SPACE: n.phase = after_bits(s.bits_left, s.proto);
         PH_BIT_MARK:  n.phase = PH_BIT_SPACE;
         PH_BIT_SPACE: begin
            n.shift_word = {s.shift_word[DATA_W-2:0], 1'b0};
            if (s.bits_left != '0) begin
               n.bits_left = s.bits_left - COUNT_W'(1);
            end
            n.phase = after_bits(n.bits_left, s.proto);
         end
         default: n.phase = PH_IDLE;
      endcase
      if (n.phase == PH_IDLE) begin
         n.seg_left = '0;
      end else begin
         n.seg_left = seg_ticks(seg_us(n.phase, n.proto, n.shift_word[DATA_W-1], cfg));
      end
      return n;
   endfunction

   assign active = accept || settle_ff;

   // next state
   always_comb begin
      logic [COUNT_W-1:0] n_bits;
      logic [CARRIER_W-1:0] top;
      mid      = st_ff;
      rejected = 1'b0;
      n_bits   = (req_word.bit_count > MAX_BITS) ? MAX_BITS : req_word.bit_count;
      top      = (st_ff.proto == PROTO_SONY) ? SONY_TOP : NEC_TOP;
      if (accept) begin
         if (req_word.command == CMD_START) begin
            if (st_ff.phase != PH_IDLE) begin
               rejected = 1'b1;
            end else begin
               mid.proto     = req_word.protocol;
               mid.bits_left = n_bits;
               if (req_word.protocol == PROTO_NEC) begin
                  mid.shift_word = req_word.frame_data;
               end else begin
                  mid.shift_word = req_word.frame_data << (MAX_BITS - n_bits);
               end
               mid.phase    = PH_HDR_MARK;
               mid.seg_left = seg_ticks(seg_us(PH_HDR_MARK, req_word.protocol, 1'b0,
                                               csr_file));
            end
         end else if (st_ff.phase != PH_IDLE) begin
            if (is_mark(st_ff.phase)) begin
               mid.carrier = (st_ff.carrier >= top) ? '0 : st_ff.carrier + CARRIER_W'(1);
            end
            if (st_ff.seg_left != '0) begin
               mid.seg_left = st_ff.seg_left - SEG_W'(1);
            end
         end
      end
      if ((mid.phase != PH_IDLE) && (mid.seg_left == '0)) begin
         after = advance_step(mid, csr_file);
      end else begin
         after = mid;
      end
      still     = (after.phase != PH_IDLE) && (after.seg_left == '0);
      st_in     = active ? after : st_ff;
      settle_in = active && still;
   end

   // outputs
   always_comb begin
      logic [CARRIER_W-1:0] cmp;
      cmp                   = (after.proto == PROTO_SONY) ? SONY_CMP : NEC_CMP;
      result.ir_level       = is_mark(after.phase) && (after.carrier <= cmp);
      result.busy_res       = after.phase != PH_IDLE;
      result.start_rejected = rejected;
      status.result_valid   = active && !still;
      status.settling       = settle_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= '{phase: PH_IDLE, default: '0};
         settle_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         settle_ff <= settle_in;
      end
   end

endmodule

[rtl/irtx_out_queue.sv]
// Two-word result queue between the sequencer and the response channel.
// Lets a new word enter while a result waits; depends on irtx_pkg.
module irtx_out_queue
   import irtx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         has_room,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   rsp_word_type q_ff [2];
   rsp_word_type q_in [2];
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = q_ff[0];
   assign has_room  = count_ff != 2'd2;

   always_comb begin
      q_in[0]  = q_ff[0];
      q_in[1]  = q_ff[1];
      count_in = count_ff;
      unique case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               q_in[0] = push_word;
            end else begin
               q_in[1] = push_word;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            q_in[0]  = q_ff[1];
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               q_in[0] = push_word;
            end else begin
               q_in[0] = q_ff[1];
               q_in[1] = push_word;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

endmodule

[rtl/ir_remote_frame_transmitter.sv]
// NEC / Sony IR frame transmitter; depends on irtx_pkg, irtx_csr, irtx_core, irtx_out_queue.
// Result: pushed into the output queue at the accepting edge, or, when zero-length segments
//   follow, once the sequencer has walked past them while settling.
// Throughput: one word per cycle while the queue has room; req_ready drops while zero-length
//   segments are skipped, but a zero-length header mark is skipped in the cycle of the start.
// Reset (synchronous): idle, carrier zero, duration registers to defaults, queue empty.
module ir_remote_frame_transmitter
   import irtx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_word_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [US_W-1:0]        csr_wdata
);

   csr_file_type    csr_file;
   core_status_type core_status;
   rsp_word_type    core_result;
   logic            has_room;
   logic            accept;

   // hold off new words while the sequencer walks skipped segments
   assign req_ready = has_room && !core_status.settling;
   assign accept    = req_valid && req_ready;

   irtx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_file  (csr_file)
   );

   irtx_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_data),
      .csr_file (csr_file),
      .result   (core_result),
      .status   (core_status)
   );

   irtx_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (core_status.result_valid),
      .push_word (core_result),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_reject_when_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.start_rejected) |-> rsp_data.busy_res)
      else $error("rejected start reported while idle");

   a_level_when_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ir_level) |-> rsp_data.busy_res)
      else $error("pin high outside a frame");

   a_settle_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(core_status.settling) |-> $past(req_valid && req_ready))
      else $error("segment walk started without an accepted word");
`endif

endmodule
